### src/lrusd_pkg.sv
// ----------------------------------------------------------------------------
// lrusd_pkg
// Shared constants for the LRU stack distance tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package lrusd_pkg;

    localparam int MAX_FRAMES_DEF = 64;
    localparam int PAGE_BITS_DEF  = 32;

    localparam int PAGE_IN_W  = 32;
    localparam int FRAMES_W   = 7;
    localparam int DEPTH_W    = 6;
    localparam int DEPTH_MAX  = 63;
    localparam int CAP_RESET  = 64;

endpackage

`default_nettype wire

### src/lru_stack_distance_tracker_core.sv
// ----------------------------------------------------------------------------
// lru_stack_distance_tracker_core
// Recency stack built from a row of compare cells; reports hit and depth.
// ----------------------------------------------------------------------------
// Operation: on accept, the per-cell match vector is registered and the
//   item becomes pending (busy); while pending, the first match is resolved,
//   the row shifts and the result strobe (done) is registered. No new item is taken while busy.
// Reset: occupancy clears, capacity returns to 64 (clamped to MAX_FRAMES);
//   cell contents stay undefined until written. The receiver cannot stall.
`default_nettype none

module lru_stack_distance_tracker_core
    import lrusd_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [PAGE_IN_W-1:0] page_number,
    input  wire logic                 cfg_we,
    input  wire logic [FRAMES_W-1:0]  cfg_wdata,
    output logic                      done,
    output logic                      hit,
    output logic [DEPTH_W-1:0]        depth
);

    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int FW = (CW > FRAMES_W) ? CW : FRAMES_W;
    localparam int KW = (PAGE_BITS > PAGE_IN_W) ? PAGE_BITS : PAGE_IN_W;
    localparam int DW = $clog2(MAX_FRAMES);
    localparam int WW = (DW > DEPTH_W) ? DW : DEPTH_W;
    localparam int CAP_RST = (CAP_RESET < MAX_FRAMES) ? CAP_RESET : MAX_FRAMES;

    logic                  pend_reg,  pend_next;
    logic [PAGE_BITS-1:0]  key_reg,   key_next;
    logic [MAX_FRAMES-1:0] match_reg, match_next;
    logic                  done_reg,  done_next;
    logic                  hit_reg,   hit_next;
    logic [DEPTH_W-1:0]    depth_reg, depth_next;
    logic [CW-1:0]         occ_reg,   occ_next;
    logic [CW-1:0]         cap_reg,   cap_next;

    logic                  accept;
    logic [KW-1:0]         key_ext;
    logic [PAGE_BITS-1:0]  key;
    logic [PAGE_BITS-1:0]  q     [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] cmp;
    logic [MAX_FRAMES-1:0] prefix;
    logic [MAX_FRAMES-1:0] first;
    logic [MAX_FRAMES-1:0] shift_en;
    logic                  any_hit;
    logic [DW-1:0]         hit_idx;
    logic [WW-1:0]         hit_idx_w;
    logic [FW-1:0]         frames_ext;
    logic [FW-1:0]         cap_wide;
    logic [CW-1:0]         cap_new;

    assign accept  = start && !pend_reg;
    assign key_ext = KW'(page_number);
    assign key     = key_ext[PAGE_BITS-1:0];

    // Row of cells
    genvar g;
    generate
        for (g = 0; g < MAX_FRAMES; g++)
        begin : g_cell
            logic [PAGE_BITS-1:0] d_in;
            if (g == 0)
            begin : g_head
                assign d_in = key_reg;
            end
            else
            begin : g_body
                assign d_in = q[g-1];
            end
            lrusd_cell #(
                .PAGE_BITS(PAGE_BITS)
            ) u_cell (
                .clk   (clk),
                .en    (shift_en[g]),
                .d_in  (d_in),
                .key   (key),
                .q     (q[g]),
                .match (cmp[g])
            );
        end
    endgenerate

    // Match resolution and shift enables
    always_comb
    begin
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            prefix[i]   = |(match_reg & ((MAX_FRAMES'(1) << i) - MAX_FRAMES'(1)));
            first[i]    = match_reg[i] && !prefix[i];
            shift_en[i] = pend_reg && !prefix[i]
                          && (CW'(i) <= occ_reg) && (CW'(i) < cap_reg);
        end
    end

    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            hit_idx = hit_idx | (first[i] ? DW'(i) : DW'(0));
        end
    end

    assign any_hit   = |match_reg;
    assign hit_idx_w = WW'(hit_idx);

    // Capacity from the written register value
    always_comb
    begin
        frames_ext = FW'(cfg_wdata);
        if (frames_ext == '0)
        begin
            cap_wide = FW'(1);
        end
        else if (frames_ext > FW'(MAX_FRAMES))
        begin
            cap_wide = FW'(MAX_FRAMES);
        end
        else
        begin
            cap_wide = frames_ext;
        end
        cap_new = CW'(cap_wide);
    end

    always_comb
    begin
        pend_next  = pend_reg;
        key_next   = key_reg;
        match_next = match_reg;
        done_next  = 1'b0;
        hit_next   = hit_reg;
        depth_next = depth_reg;
        occ_next   = occ_reg;
        cap_next   = cap_reg;

        if (accept)
        begin
            pend_next = 1'b1;
            key_next  = key;
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                match_next[i] = cmp[i] && (CW'(i) < occ_reg);
            end
        end

        if (pend_reg)
        begin
            pend_next = 1'b0;
            done_next = 1'b1;
            hit_next  = any_hit;
            if (hit_idx_w > WW'(DEPTH_MAX))
            begin
                depth_next = DEPTH_W'(DEPTH_MAX);
            end
            else
            begin
                depth_next = hit_idx_w[DEPTH_W-1:0];
            end
            if (!any_hit && (occ_reg < cap_reg))
            begin
                occ_next = occ_reg + CW'(1);
            end
        end

        if (cfg_we)
        begin
            cap_next = cap_new;
            if (occ_reg > cap_new)
            begin
                occ_next = cap_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
            occ_reg  <= '0;
            cap_reg  <= CW'(CAP_RST);
        end
        else
        begin
            pend_reg <= pend_next;
            done_reg <= done_next;
            occ_reg  <= occ_next;
            cap_reg  <= cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        match_reg <= match_next;
        hit_reg   <= hit_next;
        depth_reg <= depth_next;
    end

    assign busy  = pend_reg;
    assign done  = done_reg;
    assign hit   = hit_reg;
    assign depth = depth_reg;

endmodule

`default_nettype wire

### src/lrusd_cell.sv
// ----------------------------------------------------------------------------
// lrusd_cell
// One slot of the recency stack: holds a page, loads from its MRU-side
// neighbor when enabled, and compares its page with the lookup key.
// ----------------------------------------------------------------------------
`default_nettype none

module lrusd_cell #(
    parameter int PAGE_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [PAGE_BITS-1:0] d_in,
    input  wire logic [PAGE_BITS-1:0] key,
    output logic      [PAGE_BITS-1:0] q,
    output logic                      match
);

    logic [PAGE_BITS-1:0] page_reg;
    logic [PAGE_BITS-1:0] page_next;

    always_comb
    begin
        page_next = en ? d_in : page_reg;
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

    assign q     = page_reg;
    assign match = (page_reg == key);

endmodule

`default_nettype wire

### src/lrusd_checker.sv
// ----------------------------------------------------------------------------
// lrusd_checker
// Port-level checks for the LRU stack distance tracker, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module lrusd_checker
    import lrusd_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic                 done,
    input wire logic                 hit,
    input wire logic [DEPTH_W-1:0]   depth
);

    // Item accepted: busy next cycle, result in the cycle after that
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after item accepted");

    a_done_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("result missing two cycles after item accepted");

    a_done_only_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result strobe without a pending item");

    a_miss_depth_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (depth == '0))
        else $error("nonzero depth on a miss");

endmodule

bind lru_stack_distance_tracker_core lrusd_checker u_lrusd_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .hit   (hit),
    .depth (depth)
);

`default_nettype wire
